FILE: rtl/icmp_pkg.sv
`timescale 1ns / 1ps

package icmp_pkg;

	// frame size limits on the receive side
	localparam int unsigned MIN_FRAME_BYTES_DEF = 45;
	localparam int unsigned MAX_FRAME_BYTES_DEF = 1514;

	// generated frame
	localparam int unsigned TX_BYTES = 45;
	localparam int unsigned TX_IDX_W = $clog2(TX_BYTES);

	// configuration port
	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 48;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_LOCAL_IP    = 4'd0,
		CFG_LOCAL_MAC   = 4'd1,
		CFG_PEER_MAC    = 4'd2,
		CFG_REPLY_LIMIT = 4'd3
	} cfg_reg_t;

	localparam logic [31:0] RST_LOCAL_IP    = 32'hC0A8_010A;
	localparam logic [47:0] RST_LOCAL_MAC   = 48'h0;
	localparam logic [47:0] RST_PEER_MAC    = 48'h001C_10F5_0CAC;
	localparam logic [7:0]  RST_REPLY_LIMIT = 8'd5;

	// protocol codes
	localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
	localparam logic [7:0]  IP_PROTO_ICMP     = 8'h01;
	localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'h08;
	localparam logic [7:0]  ICMP_ECHO_REPLY   = 8'h00;
	localparam logic [7:0]  ICMP_CODE         = 8'h00;

	// fixed ipv4 header fields of the generated frame
	localparam logic [7:0]  IP_VER_IHL    = 8'h45;
	localparam logic [7:0]  IP_TOS        = 8'h00;
	localparam logic [15:0] IP_TOTAL_LEN  = 16'd31;
	localparam logic [15:0] IP_IDENT      = 16'hFACE;
	localparam logic [15:0] IP_FLAGS_FRAG = 16'h0000;
	localparam logic [7:0]  IP_TTL        = 8'hFF;

	localparam int unsigned CSUM_ACC_W = 20;

	// sum of the constant header words, addresses are added per frame
	localparam logic [CSUM_ACC_W-1:0] IP_CSUM_BASE =
		CSUM_ACC_W'({IP_VER_IHL, IP_TOS}) + CSUM_ACC_W'(IP_TOTAL_LEN) +
		CSUM_ACC_W'(IP_IDENT) + CSUM_ACC_W'(IP_FLAGS_FRAG) +
		CSUM_ACC_W'({IP_TTL, IP_PROTO_ICMP});

	localparam logic [23:0] REPLY_PAYLOAD   = 24'hFEDCBA;
	localparam logic [23:0] REQUEST_PAYLOAD = 24'hABCDEF;

	// one pending frame to send
	typedef struct packed {
		logic        is_reply;
		logic [15:0] ident;
		logic [15:0] seq;
		logic [31:0] peer_ip;
		logic [15:0] ip_csum;
		logic [15:0] icmp_csum;
	} desc_t;

	// end-around carry fold and complement
	function automatic logic [15:0] ones_fold(input logic [CSUM_ACC_W-1:0] s);
		logic [16:0] f1;
		logic [15:0] f2;
		f1 = 17'(s[15:0]) + 17'(s[CSUM_ACC_W-1:16]);
		f2 = f1[15:0] + 16'(f1[16]);
		return ~f2;
	endfunction

endpackage

FILE: rtl/icmp_rx_if.sv
`timescale 1ns / 1ps

interface icmp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       rx_last;

	modport source (output valid, output rx_byte, output rx_last, input ready);
	modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface

FILE: rtl/icmp_tx_if.sv
`timescale 1ns / 1ps

interface icmp_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       tx_last;

	modport source (output valid, output tx_byte, output tx_last, input ready);
	modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

FILE: rtl/icmp_cfg_if.sv
`timescale 1ns / 1ps

interface icmp_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [47:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/icmp_echo_responder.sv
`timescale 1ns / 1ps

// icmp echo responder
// rx  : received ethernet frame, one byte per word, rx_last on the final byte
// tx  : generated 45-byte answer frame, one byte per word, tx_last on byte 44
// cfg : register writes (0 local_ip, 1 local_mac, 2 peer_mac, 3 reply_limit),
//       always ready, unknown indexes are dropped; write only while idle
// an ipv4 icmp echo request to local_ip gets an echo reply, an echo reply gets
// a new request with the low sequence byte bumped; frames that are short,
// not ipv4/icmp, for another address or of another icmp type get nothing
// throughput: one rx word per cycle unless rx stalls; a tx frame is 45 words
// at one per cycle while tx is ready; an answer built from the last rx word in
// the input register passes the pending slot, sending slot and output register
// answers queue in two descriptor slots (sending and pending); rx only stalls
// when a third answer is ready while both slots are full, so a tx stall that
// lasts long enough backs up into rx, never drops a frame
// after reply_limit sent frames the block stays silent until reset
// reset clears the capture state, the send counter and both descriptor slots,
// and loads the register reset values

module icmp_echo_responder #(
	parameter int unsigned MIN_FRAME_BYTES = icmp_pkg::MIN_FRAME_BYTES_DEF,
	parameter int unsigned MAX_FRAME_BYTES = icmp_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	icmp_rx_if.sink         rx,
	icmp_tx_if.source       tx,
	icmp_cfg_if.sink        cfg
);
	import icmp_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [TX_IDX_W-1:0] TX_IDX_LAST = TX_IDX_W'(TX_BYTES - 1);

	// configuration registers
	logic [31:0] local_ip_q;
	logic [47:0] local_mac_q;
	logic [47:0] peer_mac_q;
	logic [7:0]  reply_limit_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// capture state
	logic [CNT_W-1:0] count_q;
	logic [15:0]      ether_type_q;
	logic [7:0]       ip_proto_q;
	logic [31:0]      peer_ip_q;
	logic [31:0]      target_ip_q;
	logic [7:0]       echo_type_q;
	logic [15:0]      echo_ident_q;
	logic [15:0]      echo_seq_q;
	logic [7:0]       sent_q;
	logic             stopped_q;

	// descriptor slots
	desc_t               act_q;
	logic                act_valid_q;
	logic [TX_IDX_W-1:0] idx_q;
	desc_t               pend_q;
	logic                pend_valid_q;

	// output register
	logic       out_valid_q;
	logic [7:0] tx_byte_q;
	logic       tx_last_q;

	// decision and descriptor for the word in the input register
	logic                  cnt_sat;
	logic [CNT_W-1:0]      count_next;
	logic                  qualifies;
	logic                  is_request;
	logic                  is_reply_in;
	logic                  send_s1;
	logic                  blocked;
	logic                  go_s1;
	logic [7:0]            sent_next;
	desc_t                 new_desc;
	logic [15:0]           seq_out;
	logic [23:0]           payload_new;
	logic [CSUM_ACC_W-1:0] ip_sum;
	logic [CSUM_ACC_W-1:0] icmp_sum;

	// transmit side
	logic   tx_adv;
	logic   act_done;
	logic   act_free;
	logic   pend_take;
	logic   push;
	logic [TX_BYTES*8-1:0] frame_w;
	logic [7:0]  type_out;
	logic [23:0] payload_out;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q    <= RST_LOCAL_IP;
			local_mac_q   <= RST_LOCAL_MAC;
			peer_mac_q    <= RST_PEER_MAC;
			reply_limit_q <= RST_REPLY_LIMIT;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_LOCAL_IP:    local_ip_q    <= cfg.data[31:0];
				CFG_LOCAL_MAC:   local_mac_q   <= cfg.data;
				CFG_PEER_MAC:    peer_mac_q    <= cfg.data;
				CFG_REPLY_LIMIT: reply_limit_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// count saturates, bytes past the limit are not captured
	assign cnt_sat    = (count_q >= CNT_W'(MAX_FRAME_BYTES));
	assign count_next = cnt_sat ? count_q : count_q + CNT_W'(1);

	// captured fields all lie before the minimum length, so the final byte
	// never needs to be looked at here
	assign is_request  = (echo_type_q == ICMP_ECHO_REQUEST);
	assign is_reply_in = (echo_type_q == ICMP_ECHO_REPLY);
	assign qualifies   = !stopped_q && (count_next >= CNT_W'(MIN_FRAME_BYTES)) &&
		(ether_type_q == ETHERTYPE_IPV4) && (ip_proto_q == IP_PROTO_ICMP) &&
		(target_ip_q == local_ip_q) && (is_request || is_reply_in);
	assign send_s1 = valid_s1 && last_s1 && qualifies;

	// descriptor build: an echo request gets a reply and vice versa
	assign seq_out = is_request ? echo_seq_q :
		{echo_seq_q[15:8], echo_seq_q[7:0] + 8'd1};
	assign payload_new = is_request ? REPLY_PAYLOAD : REQUEST_PAYLOAD;

	assign ip_sum = IP_CSUM_BASE +
		CSUM_ACC_W'(local_ip_q[31:16]) + CSUM_ACC_W'(local_ip_q[15:0]) +
		CSUM_ACC_W'(peer_ip_q[31:16]) + CSUM_ACC_W'(peer_ip_q[15:0]);

	assign icmp_sum =
		CSUM_ACC_W'({(is_request ? ICMP_ECHO_REPLY : ICMP_ECHO_REQUEST), ICMP_CODE}) +
		CSUM_ACC_W'(echo_ident_q) + CSUM_ACC_W'(seq_out) +
		CSUM_ACC_W'(payload_new[23:8]) + CSUM_ACC_W'({payload_new[7:0], 8'h00});

	always_comb begin
		new_desc.is_reply  = is_request;
		new_desc.ident     = echo_ident_q;
		new_desc.seq       = seq_out;
		new_desc.peer_ip   = peer_ip_q;
		new_desc.ip_csum   = ones_fold(ip_sum);
		new_desc.icmp_csum = ones_fold(icmp_sum);
	end

	assign sent_next = (sent_q == 8'hFF) ? sent_q : sent_q + 8'd1;

	// slot handshakes
	assign tx_adv    = act_valid_q && (!out_valid_q || tx.ready);
	assign act_done  = tx_adv && (idx_q == TX_IDX_LAST);
	assign act_free  = !act_valid_q || act_done;
	assign pend_take = pend_valid_q && act_free;

	// a new answer waits only if the pending slot stays full this cycle
	assign blocked  = send_s1 && pend_valid_q && !act_free;
	assign go_s1    = valid_s1 && !blocked;
	assign push     = go_s1 && send_s1;
	assign rx.ready = !valid_s1 || !blocked;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
			last_s1 <= rx.rx_last;
		end
	end

	// capture and frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			ether_type_q <= '0;
			ip_proto_q   <= '0;
			peer_ip_q    <= '0;
			target_ip_q  <= '0;
			echo_type_q  <= '0;
			echo_ident_q <= '0;
			echo_seq_q   <= '0;
			sent_q       <= '0;
			stopped_q    <= 1'b0;
		end else if (go_s1) begin
			if (last_s1) begin
				count_q      <= '0;
				ether_type_q <= '0;
				ip_proto_q   <= '0;
				peer_ip_q    <= '0;
				target_ip_q  <= '0;
				echo_type_q  <= '0;
				echo_ident_q <= '0;
				echo_seq_q   <= '0;
				if (send_s1) begin
					sent_q <= sent_next;
					if (sent_next >= reply_limit_q) begin
						stopped_q <= 1'b1;
					end
				end
			end else begin
				count_q <= count_next;
				if (!cnt_sat) begin
					if (count_q == CNT_W'(12) || count_q == CNT_W'(13)) begin
						ether_type_q <= {ether_type_q[7:0], byte_s1};
					end else if (count_q == CNT_W'(23)) begin
						ip_proto_q <= byte_s1;
					end else if (count_q >= CNT_W'(26) && count_q <= CNT_W'(29)) begin
						peer_ip_q <= {peer_ip_q[23:0], byte_s1};
					end else if (count_q >= CNT_W'(30) && count_q <= CNT_W'(33)) begin
						target_ip_q <= {target_ip_q[23:0], byte_s1};
					end else if (count_q == CNT_W'(34)) begin
						echo_type_q <= byte_s1;
					end else if (count_q == CNT_W'(38) || count_q == CNT_W'(39)) begin
						echo_ident_q <= {echo_ident_q[7:0], byte_s1};
					end else if (count_q == CNT_W'(40) || count_q == CNT_W'(41)) begin
						echo_seq_q <= {echo_seq_q[7:0], byte_s1};
					end
				end
			end
		end
	end

	// pending slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (pend_take) begin
			pend_valid_q <= push;
		end else if (push) begin
			pend_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			pend_q <= new_desc;
		end
	end

	// sending slot and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (pend_take) begin
			act_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (act_done) begin
			act_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (tx_adv) begin
			idx_q <= idx_q + TX_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pend_take) begin
			act_q <= pend_q;
		end
	end

	// whole answer frame laid out first byte most significant
	assign type_out    = act_q.is_reply ? ICMP_ECHO_REPLY : ICMP_ECHO_REQUEST;
	assign payload_out = act_q.is_reply ? REPLY_PAYLOAD : REQUEST_PAYLOAD;
	assign frame_w = {
		peer_mac_q, local_mac_q, ETHERTYPE_IPV4,
		IP_VER_IHL, IP_TOS, IP_TOTAL_LEN, IP_IDENT, IP_FLAGS_FRAG,
		IP_TTL, IP_PROTO_ICMP, act_q.ip_csum, local_ip_q, act_q.peer_ip,
		type_out, ICMP_CODE, act_q.icmp_csum, act_q.ident, act_q.seq,
		payload_out
	};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tx_adv) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tx_adv) begin
			tx_byte_q <= frame_w[8*(TX_BYTES-1-int'(idx_q)) +: 8];
			tx_last_q <= (idx_q == TX_IDX_LAST);
		end
	end

	assign tx.valid   = out_valid_q;
	assign tx.tx_byte = tx_byte_q;
	assign tx.tx_last = tx_last_q;

endmodule

FILE: tb/tb_icmp_echo_responder.sv
`timescale 1ns / 1ps

module tb_icmp_echo_responder;

	import icmp_pkg::*;

	// codes that only the stimulus needs
	localparam logic [3:0]  CFG_IDX_UNUSED    = 4'hF;
	localparam logic [7:0]  ICMP_DEST_UNREACH = 8'd3;

	typedef enum {SINK_FULL, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

	typedef struct {
		logic [7:0] tx_byte;
		logic       tx_last;
	} tx_word_t;

	// predicts the answer frames from the received words and checks them
	class echo_scoreboard;
		// register copies
		logic [31:0] local_ip;
		logic [47:0] local_mac;
		logic [47:0] peer_mac;
		logic [7:0]  reply_limit;
		// capture of the frame being received
		int unsigned byte_cnt;
		logic [15:0] eth_type;
		logic [7:0]  proto;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [7:0]  icmp_kind;
		logic [15:0] ident;
		logic [15:0] seq;
		// send bookkeeping
		int unsigned sent;
		bit          halted;
		logic [7:0]  answer [TX_BYTES];
		tx_word_t    tx_frame_bytes [$];
		int unsigned tx_seen;
		int unsigned mismatches;

		function new();
			local_ip    = RST_LOCAL_IP;
			local_mac   = RST_LOCAL_MAC;
			peer_mac    = RST_PEER_MAC;
			reply_limit = RST_REPLY_LIMIT;
			sent        = 0;
			halted      = 1'b0;
			tx_seen     = 0;
			mismatches  = 0;
			clear_capture();
		endfunction

		function void clear_capture();
			byte_cnt  = 0;
			eth_type  = '0;
			proto     = '0;
			src_ip    = '0;
			dst_ip    = '0;
			icmp_kind = '0;
			ident     = '0;
			seq       = '0;
		endfunction

		function void set_reg(logic [3:0] idx, logic [47:0] value);
			case (idx)
				CFG_LOCAL_IP:    local_ip    = value[31:0];
				CFG_LOCAL_MAC:   local_mac   = value;
				CFG_PEER_MAC:    peer_mac    = value;
				CFG_REPLY_LIMIT: reply_limit = value[7:0];
				default: ;
			endcase
		endfunction

		// ones' complement checksum over part of the answer frame
		function logic [15:0] fold_sum(int first, int n);
			logic [31:0] s;
			s = '0;
			for (int i = 0; i < n; i += 2) begin
				if (i + 1 < n)
					s += {answer[first + i], answer[first + i + 1]};
				else
					s += {answer[first + i], 8'h00};
			end
			while (s > 32'h0000_FFFF)
				s = (s & 32'h0000_FFFF) + (s >> 16);
			return ~s[15:0];
		endfunction

		function void build_answer(logic [7:0] kind, logic [15:0] sq, logic [23:0] pay);
			logic [15:0] ck;
			for (int i = 0; i < 6; i++) begin
				answer[i]     = peer_mac[47 - 8 * i -: 8];
				answer[6 + i] = local_mac[47 - 8 * i -: 8];
			end
			answer[12] = ETHERTYPE_IPV4[15:8];
			answer[13] = ETHERTYPE_IPV4[7:0];
			answer[14] = IP_VER_IHL;
			answer[15] = IP_TOS;
			answer[16] = IP_TOTAL_LEN[15:8];
			answer[17] = IP_TOTAL_LEN[7:0];
			answer[18] = IP_IDENT[15:8];
			answer[19] = IP_IDENT[7:0];
			answer[20] = IP_FLAGS_FRAG[15:8];
			answer[21] = IP_FLAGS_FRAG[7:0];
			answer[22] = IP_TTL;
			answer[23] = IP_PROTO_ICMP;
			answer[24] = 8'h00;
			answer[25] = 8'h00;
			for (int i = 0; i < 4; i++) begin
				answer[26 + i] = local_ip[31 - 8 * i -: 8];
				answer[30 + i] = src_ip[31 - 8 * i -: 8];
			end
			ck = fold_sum(14, 20);
			answer[24] = ck[15:8];
			answer[25] = ck[7:0];
			answer[34] = kind;
			answer[35] = ICMP_CODE;
			answer[36] = 8'h00;
			answer[37] = 8'h00;
			answer[38] = ident[15:8];
			answer[39] = ident[7:0];
			answer[40] = sq[15:8];
			answer[41] = sq[7:0];
			answer[42] = pay[23:16];
			answer[43] = pay[15:8];
			answer[44] = pay[7:0];
			ck = fold_sum(34, 11);
			answer[36] = ck[15:8];
			answer[37] = ck[7:0];
			for (int k = 0; k < TX_BYTES; k++)
				tx_frame_bytes.push_back('{tx_byte: answer[k], tx_last: (k == TX_BYTES - 1)});
		endfunction

		// one accepted rx word
		function void take_rx_word(logic [7:0] b, logic lst);
			bit go;
			go = 1'b0;
			if (byte_cnt < MAX_FRAME_BYTES_DEF) begin
				case (byte_cnt)
					12, 13:         eth_type = {eth_type[7:0], b};
					23:             proto = b;
					26, 27, 28, 29: src_ip = {src_ip[23:0], b};
					30, 31, 32, 33: dst_ip = {dst_ip[23:0], b};
					34:             icmp_kind = b;
					38, 39:         ident = {ident[7:0], b};
					40, 41:         seq = {seq[7:0], b};
					default: ;
				endcase
				byte_cnt++;
			end
			if (!lst)
				return;
			if (!halted && byte_cnt >= MIN_FRAME_BYTES_DEF && eth_type == ETHERTYPE_IPV4 &&
					proto == IP_PROTO_ICMP && dst_ip == local_ip) begin
				if (icmp_kind == ICMP_ECHO_REQUEST) begin
					build_answer(ICMP_ECHO_REPLY, seq, REPLY_PAYLOAD);
					go = 1'b1;
				end else if (icmp_kind == ICMP_ECHO_REPLY) begin
					// a reply is answered with the next request, low byte wraps
					build_answer(ICMP_ECHO_REQUEST, {seq[15:8], seq[7:0] + 8'd1},
						REQUEST_PAYLOAD);
					go = 1'b1;
				end
			end
			clear_capture();
			if (go) begin
				if (sent < 255)
					sent++;
				if (sent >= reply_limit)
					halted = 1'b1;
			end
		endfunction

		function void note_mismatch(string field, logic [7:0] exp_v, logic [7:0] act_v);
			mismatches++;
			if (mismatches <= 10)
				$display("tx word %0d: %s expected %02h got %02h", tx_seen, field, exp_v, act_v);
		endfunction

		// one accepted tx word against the oldest expectation
		function void check_tx_word(logic [7:0] b, logic lst);
			tx_word_t want;
			if (tx_frame_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tx word %0d: nothing expected, got byte %02h last %0b",
						tx_seen, b, lst);
			end else begin
				want = tx_frame_bytes.pop_front();
				if (want.tx_byte !== b)
					note_mismatch("tx_byte", want.tx_byte, b);
				if (want.tx_last !== lst)
					note_mismatch("tx_last", 8'(want.tx_last), 8'(lst));
			end
			tx_seen++;
		endfunction

		function int unsigned pending();
			return tx_frame_bytes.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	icmp_rx_if  rx ();
	icmp_tx_if  tx ();
	icmp_cfg_if cfg ();

	icmp_echo_responder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.tx     (tx),
		.cfg    (cfg)
	);

	echo_scoreboard sb = new();

	// sender pacing
	int unsigned burst_left   = 0;
	bit          sender_gappy = 1'b1;

	// receiver pacing
	sink_mode_t  sink_mode = SINK_RANDOM;
	bit          hold_req  = 1'b0;
	int unsigned hold_left = 0;
	int unsigned pat_cnt   = 0;

	always #6 clk = ~clk;

	// generous upper bound on the whole run
	initial begin
		#5_000_000;
		$display("icmp_echo_responder test failed");
		$finish;
	end

	// watch both data channels, every handshake feeds the scoreboard
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx.valid && rx.ready)
				sb.take_rx_word(rx.rx_byte, rx.rx_last);
			if (tx.valid && tx.ready)
				sb.check_tx_word(tx.tx_byte, tx.tx_last);
		end
	end

	// tx side: a long hold-off when asked, otherwise the current stall pattern
	initial begin
		tx.ready = 1'b0;
		forever begin
			@(posedge clk);
			pat_cnt++;
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 1500;
			end
			if (hold_left > 0) begin
				hold_left--;
				tx.ready <= 1'b0;
			end else begin
				case (sink_mode)
					SINK_FULL:    tx.ready <= 1'b1;
					SINK_RANDOM:  tx.ready <= ($urandom_range(0, 3) != 0);
					// low while the pattern count modulo 11 is under 4, with an odd extra stall
					SINK_PATTERN: tx.ready <= ((pat_cnt % 11) >= 4) &&
						($urandom_range(0, 15) != 0);
					default:      tx.ready <= 1'b1;
				endcase
			end
		end
	end

	// one rx word; bursts of random length, random gaps between bursts
	task automatic send_word(input logic [7:0] b, input logic lst);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = sender_gappy ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				rx.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		rx.valid   <= 1'b1;
		rx.rx_byte <= b;
		rx.rx_last <= lst;
		do @(posedge clk); while (!rx.ready);
	endtask

	// frame with ethertype, protocol, target address, icmp type and sequence set, everything else random
	task automatic drive_frame(input int unsigned len, input logic [15:0] etype,
			input logic [7:0] prot, input logic [31:0] dst, input logic [7:0] kind,
			input logic [15:0] sq);
		logic [7:0] b;
		for (int p = 0; p < len; p++) begin
			b = 8'($urandom);
			case (p)
				12: b = etype[15:8];
				13: b = etype[7:0];
				23: b = prot;
				30: b = dst[31:24];
				31: b = dst[23:16];
				32: b = dst[15:8];
				33: b = dst[7:0];
				34: b = kind;
				40: b = sq[15:8];
				41: b = sq[7:0];
				default: ;
			endcase
			send_word(b, p == len - 1);
		end
	endtask

	// ipv4 icmp frame to this node with the given length, icmp type and sequence
	task automatic send_ping(input int unsigned len, input logic [7:0] kind,
			input logic [15:0] sq);
		drive_frame(len, ETHERTYPE_IPV4, IP_PROTO_ICMP, sb.local_ip, kind, sq);
	endtask

	// stop sending and let every expected tx word come out, then settle
	task automatic drain(input int unsigned settle);
		rx.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// cfg valid stays up between back-to-back writes, lowered by the caller
	task automatic write_reg(input logic [3:0] idx, input logic [47:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		sb.set_reg(idx, value);
	endtask

	task automatic configure(input logic [31:0] ip, input logic [47:0] lmac,
			input logic [47:0] pmac, input logic [7:0] lim);
		write_reg(CFG_LOCAL_IP, 48'(ip));
		write_reg(CFG_LOCAL_MAC, lmac);
		write_reg(CFG_PEER_MAC, pmac);
		write_reg(CFG_REPLY_LIMIT, 48'(lim));
		cfg.valid <= 1'b0;
	endtask

	initial begin
		// every input known from time zero
		arst_n     = 1'b0;
		rx.valid   = 1'b0;
		rx.rx_byte = 8'h00;
		rx.rx_last = 1'b0;
		cfg.valid  = 1'b0;
		cfg.index  = 4'h0;
		cfg.data   = 48'h0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames on the reset register values
		sink_mode = SINK_PATTERN;
		send_ping(MIN_FRAME_BYTES_DEF, ICMP_ECHO_REQUEST, 16'hFFFF);
		send_ping(MIN_FRAME_BYTES_DEF, ICMP_ECHO_REPLY, 16'h12FF);   // seq low byte wraps
		send_ping(MIN_FRAME_BYTES_DEF - 1, ICMP_ECHO_REQUEST, 16'h5A5A); // one byte short
		send_ping(MIN_FRAME_BYTES_DEF, ICMP_DEST_UNREACH, 16'h0101); // other icmp type
		send_ping(1, ICMP_ECHO_REQUEST, 16'h0000);                   // last on first byte
		drain(8);

		// all-ones address and source mac, plus a dropped index; the limit of
		// five is reached by the last answer below
		write_reg(CFG_IDX_UNUSED, 48'({$urandom, $urandom}));
		configure(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h0, 8'd5);

		// long tx hold-off while answered frames keep coming: rx has to stall
		sink_mode    = SINK_RANDOM;
		sender_gappy = 1'b0;
		hold_req     = 1'b1;
		send_ping(MIN_FRAME_BYTES_DEF, ICMP_ECHO_REQUEST, 16'($urandom));
		send_ping(MIN_FRAME_BYTES_DEF, ICMP_ECHO_REPLY, 16'($urandom));
		send_ping(MIN_FRAME_BYTES_DEF, ($urandom_range(0, 1) ? ICMP_ECHO_REQUEST :
			ICMP_ECHO_REPLY), 16'($urandom));

		drain(20);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("icmp_echo_responder test passed");
		end else begin
			$display("icmp_echo_responder test failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/icmp_pkg.sv
rtl/icmp_rx_if.sv
rtl/icmp_tx_if.sv
rtl/icmp_cfg_if.sv
rtl/icmp_echo_responder.sv
tb/tb_icmp_echo_responder.sv
